FILE: sv/awlmv_pkg.sv
// Shared types and constants for the alpha-weighted layer mean/variance block.
// Field widths, register indexes and the sequencer state encoding.
// No dependencies.
package awlmv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 15;
  localparam int WT_W       = 21;
  localparam int SUM_W      = 37;
  localparam int SQSUM_W    = 53;
  localparam int SQ_W       = 31;
  localparam int RES_W      = 40;
  localparam int ALPHA_W    = 16;
  localparam int LANES      = 3;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_USER_W = 1;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [1:0] REG_ALPHA_HIGH = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RST = 16'd255;
  localparam logic [RES_W-1:0]   RES_MAX        = 40'h7F_FFFF_FFFF;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_M_SQ   = 11'b000_0000_0010,
    ST_M_WX   = 11'b000_0000_0100,
    ST_M_WSQ  = 11'b000_0000_1000,
    ST_M_ACC  = 11'b000_0001_0000,
    ST_F_CH   = 11'b000_0010_0000,
    ST_F_DIV  = 11'b000_0100_0000,
    ST_F_DONE = 11'b000_1000_0000,
    ST_F_VAR  = 11'b001_0000_0000,
    ST_F_NEXT = 11'b010_0000_0000,
    ST_F_EMIT = 11'b100_0000_0000
  } state_t;

endpackage

FILE: sv/alpha_weighted_layer_mean_variance.sv
// Alpha-weighted mean / variance of a stack of layers, reduced to one pixel.
// One sequencer drives a shared multiplier and a radix-2 restoring divider.
// Depends on awlmv_pkg.

// Each input beat is one layer (three samples, a 15-bit weight, tlast on the
// final layer). An accepted layer steps the shared multiplier through ST_M_SQ,
// ST_M_WX, ST_M_WSQ and ST_M_ACC for each channel (square, weight*sample,
// weight*square, accumulate); a layer dropped because MAX_LAYERS is reached
// or the 21-bit weight sum would overflow is not accumulated. On the last
// layer the divider runs one quotient bit per cycle over DW = 54 +
// FRACTION_BITS bits: per channel a mean takes one division and a variance
// two (mean, then mean of squares); all channels then load the output register.
// A zero weight sum skips the divisions and yields zeros with tuser set.
// in_tready is high only while the sequencer is idle; a finished result waits
// in the output register without holding off the next layer.
module alpha_weighted_layer_mean_variance
  import awlmv_pkg::*;
#(
  parameter int MAX_LAYERS    = 64,
  parameter int CHANNELS      = 3,
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample_a[15:0], sample_b[31:16], sample_c[47:32], weight[62:48], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,   // last_layer
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // result_a[39:0], result_b[79:40], result_c[119:80], out_alpha[135:120]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,  // no_weight[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
  localparam int MQ_W   = 16 + FRACTION_BITS;
  localparam int E2_W   = 31 + FRACTION_BITS;
  localparam int QW     = 32 + FRACTION_BITS;
  localparam int DW     = SQSUM_W + FRACTION_BITS + 1;
  localparam int DCNT_W = $clog2(DW);
  localparam int MUL_W  = (FRACTION_BITS + 17 > 32) ? FRACTION_BITS + 17 : 32;
  localparam int PW     = 2 * MUL_W;
  localparam int CW     = (E2_W > RES_W) ? E2_W : RES_W;
  localparam logic [PW-1:0] ROUND_HALF = (PW'(1) << FRACTION_BITS) >> 1;

  state_t state_r, state_nxt;

  logic               mode_r;
  logic [ALPHA_W-1:0] alpha_lo_r;
  logic [ALPHA_W-1:0] alpha_hi_r;

  logic [WT_W-1:0]   wt_r, wt_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r [LANES];
  logic signed [SUM_W-1:0] sum_nxt [LANES];
  logic [SQSUM_W-1:0] sqsum_r [LANES];
  logic [SQSUM_W-1:0] sqsum_nxt [LANES];
  logic [1:0]        ch_r, ch_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic signed [SAMPLE_W-1:0] x_r [LANES];
  logic signed [SAMPLE_W-1:0] x_nxt [LANES];
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic                last_r, last_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic                sign_r, sign_nxt;
  logic                phase_r, phase_nxt;
  logic [DW-1:0]       num_r, num_nxt;
  logic [WT_W-1:0]     rem_r, rem_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [MQ_W-1:0]     mq_r, mq_nxt;
  logic [E2_W-1:0]     e2_r, e2_nxt;
  logic [RES_W-1:0]    res_r [LANES];
  logic [RES_W-1:0]    res_nxt [LANES];
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic                    in_accept;
  logic                    cfg_wr;
  logic [WT_W:0]           wt_sum;
  logic                    add_ok;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [SUM_W-1:0] sum_cur;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [WT_W:0]           trial;
  logic                    trial_ge;
  logic [WT_W-1:0]         rem_step;
  logic [QW-1:0]           q_round;
  logic [MQ_W-1:0]         mq_new;
  logic [RES_W-1:0]        mean_res;
  logic [E2_W-1:0]         msq;
  logic [CW-1:0]           var_diff;
  logic [RES_W-1:0]        var_res;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:       cfg_prdata = CFG_DATA_W'(mode_r);
      REG_ALPHA_LOW:  cfg_prdata = CFG_DATA_W'(alpha_lo_r);
      REG_ALPHA_HIGH: cfg_prdata = CFG_DATA_W'(alpha_hi_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Layer admission: count limit and 21-bit weight sum headroom
  assign wt_sum = {1'b0, wt_r} + (WT_W + 1)'(in_tdata[62:48]);
  assign add_ok = (cnt_r < CNT_W'(MAX_LAYERS)) && !wt_sum[WT_W];

  assign x_cur   = x_r[ch_r];
  assign sum_cur = sum_r[ch_r];
  assign sum_mag = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);

  // Shared multiplier
  always_comb begin
    unique case (state_r)
      ST_M_SQ: begin
        mul_a = MUL_W'(x_cur);
        mul_b = MUL_W'(x_cur);
      end
      ST_M_WX: begin
        mul_a = MUL_W'(x_cur);
        mul_b = $signed(MUL_W'(w_r));
      end
      ST_M_WSQ: begin
        mul_a = $signed(MUL_W'(sq_r));
        mul_b = $signed(MUL_W'(w_r));
      end
      ST_F_DONE: begin
        mul_a = $signed(MUL_W'(mq_r));
        mul_b = $signed(MUL_W'(mq_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // One restoring-division step per cycle
  assign trial    = {rem_r, num_r[DW-1]};
  assign trial_ge = (trial >= {1'b0, wt_r});
  assign rem_step = trial_ge ? WT_W'(trial - {1'b0, wt_r}) : trial[WT_W-1:0];

  // Quotient carries one extra fraction bit; round half away from zero
  assign q_round  = (q_r + QW'(1)) >> 1;
  assign mq_new   = MQ_W'(q_round);
  assign mean_res = sign_r ? RES_W'(-RES_W'(mq_new)) : RES_W'(mq_new);

  assign msq      = E2_W'((prod_r + ROUND_HALF) >> FRACTION_BITS);
  assign var_diff = CW'(e2_r - msq);
  always_comb begin
    priority if (e2_r < msq) begin
      var_res = '0;
    end else if (var_diff > CW'(RES_MAX)) begin
      var_res = RES_MAX;
    end else begin
      var_res = var_diff[RES_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wt_nxt        = wt_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    sqsum_nxt     = sqsum_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    x_nxt         = x_r;
    w_nxt         = w_r;
    last_nxt      = last_r;
    sq_nxt        = sq_r;
    prod_nxt      = prod_r;
    sign_nxt      = sign_r;
    phase_nxt     = phase_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    mq_nxt        = mq_r;
    e2_nxt        = e2_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          x_nxt[0] = in_tdata[15:0];
          x_nxt[1] = in_tdata[31:16];
          x_nxt[2] = in_tdata[47:32];
          w_nxt    = in_tdata[62:48];
          last_nxt = in_tlast;
          ch_nxt   = '0;
          for (int i = 0; i < LANES; i++) begin
            res_nxt[i] = '0;
          end
          priority if (add_ok) begin
            wt_nxt    = wt_sum[WT_W-1:0];
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = ST_M_SQ;
          end else if (in_tlast) begin
            state_nxt = ST_F_CH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_M_SQ: begin
        sq_nxt    = mul_p[SQ_W-1:0];
        state_nxt = ST_M_WX;
      end
      ST_M_WX: begin
        prod_nxt  = mul_p;
        state_nxt = ST_M_WSQ;
      end
      ST_M_WSQ: begin
        sum_nxt[ch_r] = sum_r[ch_r] + $signed(prod_r[SUM_W-1:0]);
        prod_nxt      = mul_p;
        state_nxt     = ST_M_ACC;
      end
      ST_M_ACC: begin
        sqsum_nxt[ch_r] = sqsum_r[ch_r] + prod_r[SQSUM_W-1:0];
        if (ch_r == 2'(CHANNELS - 1)) begin
          ch_nxt    = '0;
          state_nxt = last_r ? ST_F_CH : ST_IDLE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_M_SQ;
        end
      end
      ST_F_CH: begin
        if (wt_r == '0) begin
          state_nxt = ST_F_EMIT;
        end else begin
          num_nxt   = DW'(sum_mag) << (FRACTION_BITS + 1);
          rem_nxt   = '0;
          q_nxt     = '0;
          dcnt_nxt  = DCNT_W'(DW - 1);
          sign_nxt  = sum_cur[SUM_W-1];
          phase_nxt = 1'b0;
          state_nxt = ST_F_DIV;
        end
      end
      ST_F_DIV: begin
        num_nxt  = num_r << 1;
        rem_nxt  = rem_step;
        q_nxt    = {q_r[QW-2:0], trial_ge};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == '0) begin
          state_nxt = ST_F_DONE;
        end
      end
      ST_F_DONE: begin
        if (!phase_r) begin
          mq_nxt = mq_new;
          if (!mode_r) begin
            res_nxt[ch_r] = mean_res;
            state_nxt     = ST_F_NEXT;
          end else begin
            // second division: weighted mean of squares
            num_nxt   = DW'(sqsum_r[ch_r]) << (FRACTION_BITS + 1);
            rem_nxt   = '0;
            q_nxt     = '0;
            dcnt_nxt  = DCNT_W'(DW - 1);
            phase_nxt = 1'b1;
            state_nxt = ST_F_DIV;
          end
        end else begin
          e2_nxt    = E2_W'(q_round);
          prod_nxt  = mul_p;
          state_nxt = ST_F_VAR;
        end
      end
      ST_F_VAR: begin
        res_nxt[ch_r] = var_res;
        state_nxt     = ST_F_NEXT;
      end
      ST_F_NEXT: begin
        if (ch_r == 2'(CHANNELS - 1)) begin
          state_nxt = ST_F_EMIT;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_F_CH;
        end
      end
      ST_F_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {(wt_r != '0) ? alpha_hi_r : alpha_lo_r,
                           res_r[2], res_r[1], res_r[0]};
          out_user_nxt  = OUT_USER_W'(wt_r == '0);
          out_valid_nxt = 1'b1;
          wt_nxt        = '0;
          cnt_nxt       = '0;
          for (int i = 0; i < LANES; i++) begin
            sum_nxt[i]   = '0;
            sqsum_nxt[i] = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      alpha_lo_r  <= '0;
      alpha_hi_r  <= ALPHA_HIGH_RST;
      wt_r        <= '0;
      cnt_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        sum_r[i]   <= '0;
        sqsum_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      wt_r        <= wt_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      sqsum_r     <= sqsum_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_MODE:       mode_r     <= cfg_pwdata[0];
          REG_ALPHA_LOW:  alpha_lo_r <= cfg_pwdata[ALPHA_W-1:0];
          REG_ALPHA_HIGH: alpha_hi_r <= cfg_pwdata[ALPHA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    w_r        <= w_nxt;
    last_r     <= last_nxt;
    sq_r       <= sq_nxt;
    prod_r     <= prod_nxt;
    sign_r     <= sign_nxt;
    phase_r    <= phase_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    dcnt_r     <= dcnt_nxt;
    mq_r       <= mq_nxt;
    e2_r       <= e2_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

FILE: test/alpha_weighted_layer_mean_variance_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for alpha_weighted_layer_mean_variance: layer beats in, one
// pixel result per stack out, checked against an in-bench fixed-point predictor.
// Depends on awlmv_pkg and the block's RTL.
module alpha_weighted_layer_mean_variance_tb
  import awlmv_pkg::*;
();

  localparam int MAX_LAYERS = 64;
  localparam int CHANNELS   = 3;
  localparam int FRAC       = 8;
  localparam longint unsigned WT_LIMIT = (64'd1 << WT_W) - 64'd1;

  localparam bit MODE_MEAN = 1'b0;
  localparam bit MODE_VAR  = 1'b1;

  typedef longint unsigned u64_t;

  // One layer beat: packs straight into in_tdata (a lowest).
  typedef struct packed {
    logic                  last;
    logic [WEIGHT_W-1:0]   wt;
    logic [SAMPLE_W-1:0]   c;
    logic [SAMPLE_W-1:0]   b;
    logic [SAMPLE_W-1:0]   a;
  } layer_t;

  typedef struct packed {
    logic               no_weight;
    logic [ALPHA_W-1:0] alpha;
    logic [RES_W-1:0]   c;
    logic [RES_W-1:0]   b;
    logic [RES_W-1:0]   a;
  } pixel_t;

  typedef enum logic {ROW_LAYER, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    bit          typed;
    layer_t      lay;
    pixel_t      want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predictor state and register mirror
  u64_t        wt_acc;
  longint      sum_acc [3];
  u64_t        sq_acc [3];
  int          layers_in;
  bit          mode_q;
  logic [15:0] alpha_lo;
  logic [15:0] alpha_hi;

  pixel_t pixels_due [$];
  row_t   stim_rows [$];
  int     err_count = 0;
  bit     quiet = 1'b0;
  int     ready_left = 0;

  alpha_weighted_layer_mean_variance #(
    .MAX_LAYERS(MAX_LAYERS),
    .CHANNELS(CHANNELS),
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // round(num * 2^FRAC / den), ties away from zero
  function automatic u64_t div_fix(input u64_t num, input u64_t den);
    u64_t q;
    u64_t r;
    q = num / den;
    r = num % den;
    return (q << FRAC) + ((r << FRAC) * 2 + den) / (2 * den);
  endfunction

  task automatic clear_stack();
    wt_acc = 0;
    layers_in = 0;
    for (int i = 0; i < 3; i++) begin
      sum_acc[i] = 0;
      sq_acc[i] = 0;
    end
  endtask

  task automatic fold_layer(input layer_t l, output bit has, output pixel_t px);
    longint      xs [3];
    logic [39:0] res [3];
    u64_t        w;
    u64_t        mag;
    u64_t        mq;
    u64_t        e2;
    u64_t        msq;
    u64_t        v;
    longint      s;
    longint      m;
    xs[0] = {{48{l.a[15]}}, l.a};
    xs[1] = {{48{l.b[15]}}, l.b};
    xs[2] = {{48{l.c[15]}}, l.c};
    w = l.wt;
    px = '0;
    // Drop layers past the stack or weight-sum limit; their last mark still closes the stack.
    if (layers_in < MAX_LAYERS && wt_acc + w <= WT_LIMIT) begin
      wt_acc += w;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_acc[i] += longint'(w) * xs[i];
        sq_acc[i] += w * u64_t'(xs[i] * xs[i]);
      end
      layers_in++;
    end
    has = l.last;
    if (!has) return;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
      if (wt_acc != 0 && i < CHANNELS) begin
        s = sum_acc[i];
        mag = (s < 0) ? u64_t'(-s) : u64_t'(s);
        mq = div_fix(mag, wt_acc);
        if (mode_q == MODE_MEAN) begin
          m = (s < 0) ? -longint'(mq) : longint'(mq);
          res[i] = m[39:0];
        end else begin
          e2 = div_fix(sq_acc[i], wt_acc);
          msq = (mq * mq + ((u64_t'(1) << FRAC) >> 1)) >> FRAC;
          v = (e2 >= msq) ? e2 - msq : 0;
          if (v > RES_MAX) v = RES_MAX;
          res[i] = v[39:0];
        end
      end
    end
    px.a = res[0];
    px.b = res[1];
    px.c = res[2];
    px.alpha = (wt_acc != 0) ? alpha_hi : alpha_lo;
    px.no_weight = (wt_acc == 0);
    clear_stack();
  endtask

  task automatic report(input string why, input pixel_t want, input pixel_t got);
    err_count++;
    if (err_count <= 10)
      $display("%s: exp a=%0d b=%0d c=%0d al=%0d nw=%0b | got a=%0d b=%0d c=%0d al=%0d nw=%0b",
               why, $signed(want.a), $signed(want.b), $signed(want.c), $signed(want.alpha),
               want.no_weight, $signed(got.a), $signed(got.b), $signed(got.c),
               $signed(got.alpha), got.no_weight);
  endtask

  task automatic send_layer(input layer_t l, input bit typed, input pixel_t want);
    bit     has;
    pixel_t px;
    int     gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_tdata <= {1'b0, l.wt, l.c, l.b, l.a};
    in_tlast <= l.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    fold_layer(l, has, px);
    if (has) pixels_due.insert(pixels_due.size(), typed ? want : px);
  endtask

  // Drop valid and let the block settle before touching registers.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0000, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_MODE:       mode_q = val[0];
      REG_ALPHA_LOW:  alpha_lo = val;
      REG_ALPHA_HIGH: alpha_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic layer_t rand_layer(input bit last);
    layer_t l;
    l.a = rand_sample();
    l.b = rand_sample();
    l.c = rand_sample();
    case ($urandom_range(0, 7))
      0:       l.wt = '0;
      1:       l.wt = 15'h7FFF;
      2:       l.wt = 15'($urandom_range(1, 3));
      default: l.wt = 15'($urandom_range(0, 32767));
    endcase
    l.last = last;
    return l;
  endfunction

  task automatic put_layer(input logic [15:0] a, b, c, input logic [14:0] w, input bit last);
    row_t r;
    r = '0;
    r.kind = ROW_LAYER;
    r.lay = {last, w, c, b, a};
    stim_rows.insert(stim_rows.size(), r);
  endtask

  // Last-layer row whose result is typed in by hand
  task automatic put_known(input logic [15:0] a, b, c, input logic [14:0] w,
                           input longint ra, rb, rc, input logic [15:0] al, input bit nw);
    row_t r;
    r = '0;
    r.kind = ROW_LAYER;
    r.lay = {1'b1, w, c, b, a};
    r.typed = 1'b1;
    r.want = {nw, al, rc[39:0], rb[39:0], ra[39:0]};
    stim_rows.insert(stim_rows.size(), r);
  endtask

  task automatic put_cfg(input logic [1:0] idx, input logic [15:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    stim_rows.insert(stim_rows.size(), r);
  endtask

  // Result receiver: stalls come in bursts; none once the run goes quiet.
  always @(negedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (ready_left == 0) begin
      out_tready <= ($urandom_range(0, 2) != 0);
      ready_left = $urandom_range(1, 12) - 1;
    end else begin
      ready_left--;
    end
  end

  always @(posedge clk) begin : watch_out
    pixel_t got;
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.a = out_tdata[39:0];
      got.b = out_tdata[79:40];
      got.c = out_tdata[119:80];
      got.alpha = out_tdata[135:120];
      got.no_weight = out_tuser[0];
      if (pixels_due.size() == 0) begin
        report("unexpected beat", '0, got);
      end else begin
        want = pixels_due.pop_front();
        if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
            got.alpha !== want.alpha || got.no_weight !== want.no_weight)
          report("mismatch", want, got);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int sent;
    int len;
    mode_q = MODE_MEAN;
    alpha_lo = 16'h0000;
    alpha_hi = ALPHA_HIGH_RST;
    clear_stack();

    // Reset-state registers: zero weight, extremes at unit weight, maximum weight
    put_known(16'd5, -16'sd7, 16'd9, 15'd0, 0, 0, 0, 16'h0000, 1'b1);
    put_known(16'h7FFF, 16'h8000, 16'h0000, 15'd1, 8388352, -8388608, 0, 16'd255, 1'b0);
    put_known(-16'sd1, 16'd1, 16'd12345, 15'h7FFF, -256, 256, 3160320, 16'd255, 1'b0);
    put_layer(16'd100, -16'sd200, 16'd300, 15'd10, 1'b0);
    put_layer(16'd0, 16'd0, 16'd0, 15'd0, 1'b0);
    put_layer(16'h8000, 16'h7FFF, -16'sd1, 15'h7FFF, 1'b1);
    put_layer(16'd1, 16'd2, 16'd3, 15'd0, 1'b0);
    put_known(16'd4, 16'd5, 16'd6, 15'd0, 0, 0, 0, 16'h0000, 1'b1);
    put_cfg(REG_ALPHA_LOW, 16'h8000);
    put_cfg(REG_ALPHA_HIGH, 16'h7FFF);
    put_cfg(REG_MODE, {15'd0, MODE_VAR});
    put_known(16'd100, -16'sd100, 16'd0, 15'd5, 0, 0, 0, 16'h7FFF, 1'b0);
    put_known(16'd0, 16'd0, 16'd0, 15'd0, 0, 0, 0, 16'h8000, 1'b1);
    put_layer(16'd0, 16'h7FFF, 16'h8000, 15'd1, 1'b0);
    put_layer(16'd2, 16'h8000, 16'h7FFF, 15'd1, 1'b1);
    put_layer(16'h7FFF, 16'h7FFF, 16'h8000, 15'h7FFF, 1'b0);
    put_layer(16'h8000, 16'h8000, 16'h7FFF, 15'h7FFF, 1'b1);
    put_cfg(REG_MODE, {15'd0, MODE_MEAN});
    put_cfg(REG_ALPHA_HIGH, 16'h8000);
    put_cfg(REG_ALPHA_LOW, 16'h7FFF);
    // Half-step means: ties round away from zero
    put_layer(16'd1, -16'sd1, 16'd3, 15'd1, 1'b0);
    put_layer(16'd0, 16'd0, 16'd0, 15'd511, 1'b1);
    put_known(16'd0, 16'd0, 16'd0, 15'd0, 0, 0, 0, 16'h7FFF, 1'b1);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_cfg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_layer(stim_rows[i].lay, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Overlong stack: layers past the limit are dropped, the last mark still ends it
    for (int k = 0; k < 70; k++) send_layer(rand_layer(k == 69), 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_cfg(REG_MODE, {15'd0, ph[0] ? MODE_MEAN : MODE_VAR});
      write_cfg(REG_ALPHA_LOW, (ph == 2) ? 16'h7FFF : 16'($urandom));
      write_cfg(REG_ALPHA_HIGH, (ph == 2) ? 16'h8000 : 16'($urandom));
      if (ph == 3) quiet = 1'b1;
      sent = 0;
      while (sent < 75) begin
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) send_layer(rand_layer(k == len - 1), 1'b0, '0);
        sent += len;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (err_count == 0 && pixels_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
